// ----- src/msp_pkg.sv -----
// Shared types and constants for the MIDI stream parser.
package msp_pkg;

   // Request: one received byte or a learn-mode write.
   typedef struct packed {
      logic       cmd;
      logic [7:0] in_byte;
      logic       learn_enable;
   } req_type;

   // Decoded message event.
   typedef struct packed {
      logic [4:0]  event_res;
      logic [3:0]  channel;
      logic [6:0]  first_value;
      logic [6:0]  second_value;
      logic [13:0] wide_value;
      logic        learn_hit;
   } rsp_type;

   // Request command codes
   localparam logic CMD_BYTE  = 1'b0;
   localparam logic CMD_LEARN = 1'b1;

   // Event codes
   localparam logic [4:0] EV_NOTEOFF   = 5'd0;
   localparam logic [4:0] EV_NOTEON    = 5'd1;
   localparam logic [4:0] EV_KEYPRESS  = 5'd2;
   localparam logic [4:0] EV_CC        = 5'd3;
   localparam logic [4:0] EV_PROG      = 5'd4;
   localparam logic [4:0] EV_CHANPRESS = 5'd5;
   localparam logic [4:0] EV_BEND      = 5'd6;
   localparam logic [4:0] EV_SONGPOS   = 5'd7;
   localparam logic [4:0] EV_SONGSEL   = 5'd8;
   localparam logic [4:0] EV_TICK      = 5'd9;
   localparam logic [4:0] EV_START     = 5'd10;
   localparam logic [4:0] EV_CONTINUE  = 5'd11;
   localparam logic [4:0] EV_STOP      = 5'd12;
   localparam logic [4:0] EV_SENSING   = 5'd13;
   localparam logic [4:0] EV_RESET     = 5'd14;
   localparam logic [4:0] EV_SX_START  = 5'd15;
   localparam logic [4:0] EV_SX_DATA   = 5'd16;
   localparam logic [4:0] EV_SX_END    = 5'd17;

   // Status bytes
   localparam logic [7:0] ST_NONE     = 8'h00;
   localparam logic [7:0] ST_SYSEX    = 8'hF0;
   localparam logic [7:0] ST_SONGPOS  = 8'hF2;
   localparam logic [7:0] ST_SONGSEL  = 8'hF3;
   localparam logic [7:0] ST_SX_END   = 8'hF7;
   localparam logic [7:0] ST_TICK     = 8'hF8;
   localparam logic [7:0] ST_START    = 8'hFA;
   localparam logic [7:0] ST_CONTINUE = 8'hFB;
   localparam logic [7:0] ST_STOP     = 8'hFC;
   localparam logic [7:0] ST_SENSING  = 8'hFE;
   localparam logic [7:0] ST_RESET    = 8'hFF;

   // Channel message kinds (upper nibble of the status byte)
   localparam logic [3:0] KIND_NOTEOFF   = 4'h8;
   localparam logic [3:0] KIND_NOTEON    = 4'h9;
   localparam logic [3:0] KIND_KEYPRESS  = 4'hA;
   localparam logic [3:0] KIND_CC        = 4'hB;
   localparam logic [3:0] KIND_PROG      = 4'hC;
   localparam logic [3:0] KIND_CHANPRESS = 4'hD;
   localparam logic [3:0] KIND_SYSTEM    = 4'hF;

endpackage

// ----- src/midi_stream_parser.sv -----
// MIDI stream parser top level: byte decoder, parse state and result register.
//
// Takes one request per clock: either a received MIDI byte or a learn-mode
// write. Each byte is decoded in the cycle it is accepted, against the parse
// state (phase, running status and channel, held first data byte, learn
// flag), and any event it completes is written into the result register.
// The block sustains one request per cycle; the only thing that holds
// off requests is the result register when it is full and its consumer
// stalls, so req_stall follows rsp_stall whenever a result is waiting.
// Realtime bytes produce an event without touching the parse; undefined
// status bytes, stray data bytes and learn writes produce none.
module midi_stream_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  msp_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output msp_pkg::rsp_type  rsp_data
);
   import msp_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_DATA0 = 2'd1,
      PH_DATA1 = 2'd2,
      PH_SYSEX = 2'd3
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  status_ff, status_in;
   logic [3:0]  chan_ff, chan_in;
   logic        allowed_ff, allowed_in;
   logic [6:0]  held_ff, held_in;
   logic        learn_ff, learn_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        accept;
   logic        emit;
   logic        load;
   logic [7:0]  b;
   logic [6:0]  comp_d0;
   logic [6:0]  comp_d1;
   logic        comp_emit;
   logic        comp_chan;
   rsp_type     comp_rsp;

   assign accept    = req_valid & ~req_stall;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign b         = req_data.in_byte;

   // Data bytes of the message being completed
   assign comp_d0 = (phase_ff == PH_DATA0) ? b[6:0] : held_ff;
   assign comp_d1 = (phase_ff == PH_DATA1) ? b[6:0] : 7'd0;
   assign comp_chan = status_ff[7] && (status_ff[7:4] != KIND_SYSTEM);

   // Build the event that completes the current message
   always_comb begin
      comp_rsp  = '0;
      comp_emit = 1'b0;
      if (status_ff == ST_SONGPOS) begin
         comp_emit           = 1'b1;
         comp_rsp.event_res  = EV_SONGPOS;
         comp_rsp.wide_value = {comp_d1, comp_d0};
      end else if (status_ff == ST_SONGSEL) begin
         comp_emit            = 1'b1;
         comp_rsp.event_res   = EV_SONGSEL;
         comp_rsp.first_value = comp_d0;
      end else if (comp_chan) begin
         comp_emit          = 1'b1;
         comp_rsp.channel   = chan_ff;
         comp_rsp.learn_hit = learn_ff;
         case (status_ff[7:4])
            KIND_NOTEOFF: begin
               comp_rsp.event_res   = EV_NOTEOFF;
               comp_rsp.first_value = comp_d0;
            end
            KIND_NOTEON: begin
               comp_rsp.first_value = comp_d0;
               if (comp_d1 == 7'd0) begin
                  comp_rsp.event_res = EV_NOTEOFF;
               end else begin
                  comp_rsp.event_res    = EV_NOTEON;
                  comp_rsp.second_value = comp_d1;
               end
            end
            KIND_KEYPRESS: begin
               comp_rsp.event_res    = EV_KEYPRESS;
               comp_rsp.first_value  = comp_d0;
               comp_rsp.second_value = comp_d1;
            end
            KIND_CC: begin
               comp_rsp.event_res    = EV_CC;
               comp_rsp.first_value  = comp_d0;
               comp_rsp.second_value = comp_d1;
            end
            KIND_PROG: begin
               comp_rsp.event_res   = EV_PROG;
               comp_rsp.first_value = comp_d0;
            end
            KIND_CHANPRESS: begin
               comp_rsp.event_res   = EV_CHANPRESS;
               comp_rsp.first_value = comp_d0;
            end
            default: begin
               comp_rsp.event_res  = EV_BEND;
               comp_rsp.wide_value = {comp_d1, comp_d0};
            end
         endcase
      end
   end

   // Decode the accepted request and advance the parse state
   always_comb begin
      phase_in    = phase_ff;
      status_in   = status_ff;
      chan_in     = chan_ff;
      allowed_in  = allowed_ff;
      held_in     = held_ff;
      learn_in    = learn_ff;
      emit        = 1'b0;
      rsp_data_in = '0;
      if (accept) begin
         if (req_data.cmd == CMD_LEARN) begin
            learn_in = req_data.learn_enable;
         end else if (b[7] && (b[7:4] == KIND_SYSTEM)) begin
            // System bytes: realtime passes through, defined common bytes restart the parse
            case (b)
               ST_TICK: begin
                  emit = 1'b1;
                  rsp_data_in.event_res = EV_TICK;
               end
               ST_START: begin
                  emit = 1'b1;
                  rsp_data_in.event_res = EV_START;
               end
               ST_CONTINUE: begin
                  emit = 1'b1;
                  rsp_data_in.event_res = EV_CONTINUE;
               end
               ST_STOP: begin
                  emit = 1'b1;
                  rsp_data_in.event_res = EV_STOP;
               end
               ST_SENSING: begin
                  emit = 1'b1;
                  rsp_data_in.event_res = EV_SENSING;
               end
               ST_RESET: begin
                  emit = 1'b1;
                  rsp_data_in.event_res = EV_RESET;
               end
               ST_SONGPOS, ST_SONGSEL: begin
                  allowed_in = 1'b0;
                  status_in  = b;
                  phase_in   = PH_DATA0;
               end
               ST_SYSEX: begin
                  allowed_in = 1'b0;
                  status_in  = b;
                  phase_in   = PH_SYSEX;
                  emit       = 1'b1;
                  rsp_data_in.event_res = EV_SX_START;
               end
               ST_SX_END: begin
                  allowed_in = 1'b0;
                  status_in  = ST_NONE;
                  phase_in   = PH_IDLE;
                  emit       = 1'b1;
                  rsp_data_in.event_res = EV_SX_END;
               end
               default: begin
                  // drop undefined status bytes
               end
            endcase
         end else if (b[7]) begin
            // Channel status: start a new running status
            chan_in    = b[3:0];
            allowed_in = 1'b1;
            status_in  = {b[7:4], 4'h0};
            phase_in   = PH_DATA0;
         end else begin
            case (phase_ff)
               PH_DATA0: begin
                  held_in = b[6:0];
                  if ((status_ff == ST_SONGSEL) ||
                      (status_ff == {KIND_PROG, 4'h0}) ||
                      (status_ff == {KIND_CHANPRESS, 4'h0})) begin
                     emit        = comp_emit;
                     rsp_data_in = comp_rsp;
                     if (comp_chan) learn_in = 1'b0;
                     phase_in = allowed_ff ? PH_DATA0 : PH_IDLE;
                  end else begin
                     phase_in = PH_DATA1;
                  end
               end
               PH_DATA1: begin
                  emit        = comp_emit;
                  rsp_data_in = comp_rsp;
                  if (comp_chan) learn_in = 1'b0;
                  phase_in = allowed_ff ? PH_DATA0 : PH_IDLE;
               end
               PH_SYSEX: begin
                  emit = 1'b1;
                  rsp_data_in.event_res   = EV_SX_DATA;
                  rsp_data_in.first_value = b[6:0];
               end
               default: begin
                  // drop stray data bytes
               end
            endcase
         end
      end
   end

   // Load the result register or hold it while stalled
   assign load         = accept & emit;
   assign rsp_valid_in = load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         status_ff    <= ST_NONE;
         chan_ff      <= 4'h0;
         allowed_ff   <= 1'b1;
         held_ff      <= 7'd0;
         learn_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
      end else begin
         phase_ff     <= phase_in;
         status_ff    <= status_in;
         chan_ff      <= chan_in;
         allowed_ff   <= allowed_in;
         held_ff      <= held_in;
         learn_ff     <= learn_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            rsp_data_ff <= rsp_data_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A learn hit consumes the learn flag
   a_learn_clears: assert property (@(posedge clock) disable iff (reset)
      (load && rsp_data_in.learn_hit) |=> !learn_ff)
      else $error("learn flag still armed after a learn hit");

   // Non-channel events carry no channel and no learn hit
   a_sys_no_chan: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.event_res > EV_BEND)) |->
      (rsp_data_ff.channel == 4'h0 && !rsp_data_ff.learn_hit))
      else $error("system event carries channel or learn hit");

   // Waiting for a second data byte needs a status that takes one
   a_data1_status: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA1) |-> (comp_chan || status_ff == ST_SONGPOS))
      else $error("second data phase under a status without one");

   // A new result appears only after an accepted request
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_valid && !req_stall))
      else $error("result appeared without an accepted request");

endmodule

// ----- bench/midi_stream_parser_tb.sv -----
// Self-checking bench for midi_stream_parser: predicted MIDI events against decoded output.
module midi_stream_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import msp_pkg::*;

   typedef enum logic [1:0] {PH_IDLE, PH_FIRST, PH_SECOND, PH_SYSEX} parse_phase_type;

   // Tracks the parse of the byte stream and holds the events still owed by the block.
   class midi_event_scoreboard_type;
      parse_phase_type phase_now;
      logic [7:0]      status_byte;
      logic [3:0]      chan_now;
      logic            running_ok;
      logic [6:0]      first_byte;
      logic            learn_armed;
      rsp_type         events_due[$];
      int              mismatches;
      int              events_checked;
      int              requests_seen;
      int              kind_count[int'(EV_SX_END) + 1];

      function new();
         phase_now      = PH_IDLE;
         status_byte    = ST_NONE;
         chan_now       = '0;
         running_ok     = 1'b1;
         first_byte     = '0;
         learn_armed    = 1'b0;
         mismatches     = 0;
         events_checked = 0;
         requests_seen  = 0;
         foreach (kind_count[k]) kind_count[k] = 0;
      endfunction

      // Close the message in progress; returns 0 when the status yields no event.
      function bit finish_message(logic [6:0] last_byte, output rsp_type ev);
         ev = '0;
         if (status_byte == ST_SONGPOS) begin
            ev.event_res  = EV_SONGPOS;
            ev.wide_value = {last_byte, first_byte};
            return 1'b1;
         end
         if (status_byte == ST_SONGSEL) begin
            ev.event_res   = EV_SONGSEL;
            ev.first_value = first_byte;
            return 1'b1;
         end
         if (!status_byte[7] || status_byte[7:4] == KIND_SYSTEM) return 1'b0;
         // channel message: consume the learn flag
         ev.channel   = chan_now;
         ev.learn_hit = learn_armed;
         learn_armed  = 1'b0;
         case (status_byte[7:4])
            KIND_NOTEOFF: begin
               ev.event_res   = EV_NOTEOFF;
               ev.first_value = first_byte;
            end
            KIND_NOTEON: begin
               ev.first_value = first_byte;
               if (last_byte == '0) begin
                  ev.event_res = EV_NOTEOFF;
               end else begin
                  ev.event_res    = EV_NOTEON;
                  ev.second_value = last_byte;
               end
            end
            KIND_KEYPRESS: begin
               ev.event_res    = EV_KEYPRESS;
               ev.first_value  = first_byte;
               ev.second_value = last_byte;
            end
            KIND_CC: begin
               ev.event_res    = EV_CC;
               ev.first_value  = first_byte;
               ev.second_value = last_byte;
            end
            KIND_PROG: begin
               ev.event_res   = EV_PROG;
               ev.first_value = first_byte;
            end
            KIND_CHANPRESS: begin
               ev.event_res   = EV_CHANPRESS;
               ev.first_value = first_byte;
            end
            default: begin
               ev.event_res  = EV_BEND;
               ev.wide_value = {last_byte, first_byte};
            end
         endcase
         return 1'b1;
      endfunction

      // Advance the parse by one accepted request and queue the event it causes.
      function void note_request(req_type r);
         rsp_type    ev;
         logic [7:0] b;
         bit         emit;
         requests_seen++;
         ev   = '0;
         emit = 1'b0;
         b    = r.in_byte;
         if (r.cmd == CMD_LEARN) begin
            learn_armed = r.learn_enable;
            return;
         end
         if (b[7] && b[7:4] != KIND_SYSTEM) begin
            // channel status: new running status
            chan_now    = b[3:0];
            running_ok  = 1'b1;
            status_byte = {b[7:4], 4'h0};
            phase_now   = PH_FIRST;
         end else if (b[7]) begin
            case (b)
               ST_TICK:     begin emit = 1'b1; ev.event_res = EV_TICK;     end
               ST_START:    begin emit = 1'b1; ev.event_res = EV_START;    end
               ST_CONTINUE: begin emit = 1'b1; ev.event_res = EV_CONTINUE; end
               ST_STOP:     begin emit = 1'b1; ev.event_res = EV_STOP;     end
               ST_SENSING:  begin emit = 1'b1; ev.event_res = EV_SENSING;  end
               ST_RESET:    begin emit = 1'b1; ev.event_res = EV_RESET;    end
               ST_SONGPOS, ST_SONGSEL: begin
                  running_ok  = 1'b0;
                  status_byte = b;
                  phase_now   = PH_FIRST;
               end
               ST_SYSEX: begin
                  running_ok   = 1'b0;
                  status_byte  = b;
                  phase_now    = PH_SYSEX;
                  emit         = 1'b1;
                  ev.event_res = EV_SX_START;
               end
               ST_SX_END: begin
                  running_ok   = 1'b0;
                  status_byte  = ST_NONE;
                  phase_now    = PH_IDLE;
                  emit         = 1'b1;
                  ev.event_res = EV_SX_END;
               end
               default: ;
            endcase
         end else begin
            case (phase_now)
               PH_FIRST: begin
                  first_byte = b[6:0];
                  if (status_byte == ST_SONGSEL || status_byte[7:4] == KIND_PROG ||
                      status_byte[7:4] == KIND_CHANPRESS) begin
                     emit      = finish_message('0, ev);
                     phase_now = running_ok ? PH_FIRST : PH_IDLE;
                  end else begin
                     phase_now = PH_SECOND;
                  end
               end
               PH_SECOND: begin
                  emit      = finish_message(b[6:0], ev);
                  phase_now = running_ok ? PH_FIRST : PH_IDLE;
               end
               PH_SYSEX: begin
                  emit           = 1'b1;
                  ev.event_res   = EV_SX_DATA;
                  ev.first_value = b[6:0];
               end
               default: ;
            endcase
         end
         if (emit) events_due.push_back(ev);
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("mismatch: %s", what);
      endtask

      task compare_field(string name, logic [13:0] got, logic [13:0] want);
         if (got !== want)
            report_mismatch($sformatf("event %0d %s got %0h want %0h",
                                      events_checked, name, got, want));
      endtask

      // Compare one decoded event with the oldest prediction.
      task check_event(rsp_type got);
         rsp_type want;
         if (events_due.size() == 0) begin
            report_mismatch($sformatf("unpredicted event, code %0d", got.event_res));
            return;
         end
         want = events_due.pop_front();
         events_checked++;
         kind_count[want.event_res]++;
         compare_field("event_res", 14'(got.event_res), 14'(want.event_res));
         compare_field("channel", 14'(got.channel), 14'(want.channel));
         compare_field("first_value", 14'(got.first_value), 14'(want.first_value));
         compare_field("second_value", 14'(got.second_value), 14'(want.second_value));
         compare_field("wide_value", got.wide_value, want.wide_value);
         compare_field("learn_hit", 14'(got.learn_hit), 14'(want.learn_hit));
      endtask
   endclass

   localparam int PHASES          = 4;
   localparam int ITEMS_PER_PHASE = 490;
   localparam logic [3:0] KIND_BEND = 4'hE;
   localparam logic [7:0] UNDEFINED_STATUS [6] = '{8'hF1, 8'hF4, 8'hF5, 8'hF6, 8'hF9, 8'hFD};
   localparam logic [7:0] REALTIME_STATUS [6] =
      '{ST_TICK, ST_START, ST_CONTINUE, ST_STOP, ST_SENSING, ST_RESET};
   localparam int IDLE_MIX [PHASES]  = '{0, 84, 0, 24};
   localparam int STALL_MIX [PHASES] = '{0, 0, 84, 24};

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int                        send_idle_pct;
   int                        recv_stall_pct;
   midi_event_scoreboard_type tracker;
   req_type                   byte_plan[$];

   midi_stream_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic req_type midi_byte(logic [7:0] b);
      req_type r;
      r.cmd          = CMD_BYTE;
      r.in_byte      = b;
      r.learn_enable = 1'($urandom_range(1));
      return r;
   endfunction

   function automatic req_type learn_write(logic on);
      req_type r;
      r.cmd          = CMD_LEARN;
      r.in_byte      = 8'($urandom_range(255));
      r.learn_enable = on;
      return r;
   endfunction

   // Data byte, biased toward the extremes.
   function automatic logic [7:0] data_value();
      int pick;
      pick = $urandom_range(15);
      if (pick == 0) return 8'h00;
      if (pick == 1) return 8'h7F;
      return 8'($urandom_range(127));
   endfunction

   // Queue a byte, now and then preceded by a realtime byte.
   function automatic void push_byte(logic [7:0] b);
      if ($urandom_range(11) == 0)
         byte_plan.push_back(midi_byte(REALTIME_STATUS[$urandom_range(5)]));
      byte_plan.push_back(midi_byte(b));
   endfunction

   // Queue one message or a bit of noise; returns how many requests count toward the phase.
   function automatic int plan_burst();
      int         pick;
      int         start_size;
      int         repeats;
      logic [3:0] kind;
      logic [3:0] chan;
      pick       = $urandom_range(99);
      start_size = byte_plan.size();
      if (pick < 55) begin
         // channel message with a few running-status repeats
         kind    = KIND_NOTEOFF + 4'($urandom_range(6));
         chan    = 4'($urandom_range(15));
         repeats = $urandom_range(1, 4);
         push_byte({kind, chan});
         for (int i = 0; i < repeats; i++) begin
            push_byte(data_value());
            if (kind != KIND_PROG && kind != KIND_CHANPRESS) push_byte(data_value());
         end
      end else if (pick < 65) begin
         if ($urandom_range(1)) begin
            push_byte(ST_SONGPOS);
            push_byte(data_value());
            push_byte(data_value());
         end else begin
            push_byte(ST_SONGSEL);
            push_byte(data_value());
         end
      end else if (pick < 77) begin
         // sysex, usually closed, otherwise cut off by the next message
         push_byte(ST_SYSEX);
         repeats = $urandom_range(5);
         for (int i = 0; i < repeats; i++) push_byte(data_value());
         if ($urandom_range(4) != 0) push_byte(ST_SX_END);
      end else if (pick < 85) begin
         byte_plan.push_back(learn_write(1'($urandom_range(2) != 0)));
      end else if (pick < 92) begin
         byte_plan.push_back(midi_byte(REALTIME_STATUS[$urandom_range(5)]));
      end else begin
         // noise: undefined status or any byte at all, not counted
         if ($urandom_range(1))
            byte_plan.push_back(midi_byte(UNDEFINED_STATUS[$urandom_range(5)]));
         else
            byte_plan.push_back(midi_byte(8'($urandom_range(255))));
         return 0;
      end
      return byte_plan.size() - start_size;
   endfunction

   // Offer one request, idling first at the current rate, and hold it until accepted.
   task automatic send_request(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_request(r);
   endtask

   task automatic drain_plan();
      while (byte_plan.size() != 0) send_request(byte_plan.pop_front());
   endtask

   // Hold off the sender until every predicted event has arrived.
   task automatic wait_for_events();
      req_valid <= 1'b0;
      while (tracker.events_due.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Stimulus
   initial begin
      int counted;
      int kinds_seen;
      tracker        = new();
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_data       <= '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, running status, zero velocity, learn, sysex cut-off,
      // undefined status, stray data, realtime inside a message
      byte_plan = '{
         learn_write(1'b1),
         midi_byte({KIND_NOTEON, 4'h0}), midi_byte(8'h00), midi_byte(8'h7F),
         midi_byte(8'h3C), midi_byte(ST_TICK), midi_byte(8'h00),
         midi_byte({KIND_NOTEOFF, 4'hF}), midi_byte(8'h7F), midi_byte(8'h40),
         midi_byte({KIND_PROG, 4'h9}), midi_byte(8'h05), midi_byte(8'h06),
         midi_byte({KIND_BEND, 4'h3}), midi_byte(8'h7F), midi_byte(8'h7F),
         midi_byte(ST_SONGPOS), midi_byte(8'h01), midi_byte(8'h02), midi_byte(8'h03),
         midi_byte(ST_SONGSEL), midi_byte(8'h7F),
         midi_byte(ST_SYSEX), midi_byte(8'h11), midi_byte({KIND_NOTEON, 4'h2}),
         midi_byte(8'h22), midi_byte(8'h33),
         midi_byte(ST_SX_END), midi_byte(UNDEFINED_STATUS[0]), midi_byte(ST_RESET),
         learn_write(1'b0)
      };
      drain_plan();
      wait_for_events();

      // random traffic under each idle/stall mix
      for (int p = 0; p < PHASES; p++) begin
         send_idle_pct  = IDLE_MIX[p];
         recv_stall_pct = STALL_MIX[p];
         counted        = 0;
         while (counted < ITEMS_PER_PHASE) begin
            counted += plan_burst();
            drain_plan();
         end
         wait_for_events();
      end

      // let any stray late event show up
      recv_stall_pct = 0;
      repeat (8) @(posedge clock);

      kinds_seen = 0;
      foreach (tracker.kind_count[k]) if (tracker.kind_count[k] != 0) kinds_seen++;
      $display("Ran %0d requests through four idle/stall mixes; %0d events checked,",
               tracker.requests_seen, tracker.events_checked);
      $display("%0d of %0d event kinds decoded, %0d mismatches.",
               kinds_seen, int'(EV_SX_END) + 1, tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("[midi_stream_parser] OK");
      end else begin
         $display("[midi_stream_parser] ERROR");
      end
      $finish;
   end

   // Result side: check accepted events, stall at the current rate
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) tracker.check_event(rsp_data);
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Watchdog
   initial begin
      #5ms;
      $display("[midi_stream_parser] ERROR");
      $finish;
   end

endmodule
